### hw/rtl/erm_pkg.sv
// erm_pkg: shared types and fixed constants of the event rate and age monitor
// no dependencies; imported by the monitor top and the checker
package erm_pkg;

  localparam int TIME_W     = 32;
  localparam int CHAN_W     = 2;
  localparam int WIN_W      = 16;
  localparam int RATE_W     = 25;
  localparam int SCALE_W    = 17;

  localparam logic [RATE_W-1:0]  RATE_MAX     = 25'h1FF_FFFF;
  localparam logic [SCALE_W-1:0] RATE_SCALE   = 17'd100000;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 16'd5000;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] now_ms;
  } in_xact_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_id;
    logic [TIME_W-1:0] age_ms;
    logic              rate_valid;
    logic [RATE_W-1:0] rate_centihz;
    logic              last_result;
  } out_xact_t;

endpackage

### hw/rtl/erm_stamp_ram.sv
// erm_stamp_ram: timestamp memory, one write port and one registered read port
// no dependencies
module erm_stamp_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/erm_div.sv
// erm_div: iterative restoring divider, one quotient bit per cycle
// no dependencies
module erm_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             active_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(NUM_W - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (active_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(diff) : DEN_W'(trial);
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

### hw/rtl/event_rate_and_age_monitor_top.sv
// event_rate_and_age_monitor_top: per-channel timestamp rings, pruning and rate sequencer
// depends on erm_pkg, erm_stamp_ram, erm_div
//
//  channel   ports                          transaction when
//  input     start, busy, in_xact           start high and busy low
//  result    out_valid, out_xact            out_valid high, one cycle each
//  config    cfg_we, cfg_wdata              cfg_we high
//
// a record is taken only while idle and busy stays low
// a report walks the channels in order; per channel it reads and checks each
// entry examined by the prune, reads the newest entry when one survives, and
// runs the serial divider for a rate when two or more survive over a nonzero span
// results never come back to back and cannot be held off
// reset is synchronous; the timestamp memory needs no clearing
module event_rate_and_age_monitor_top #(
  parameter int NUM_CHANNELS = 4,
  parameter int RING_DEPTH   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  erm_pkg::in_xact_t  in_xact,
  output logic               out_valid,
  output erm_pkg::out_xact_t out_xact,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  import erm_pkg::*;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HEAD_W    = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CHANNELS * RING_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int NUM_W     = CNT_W + SCALE_W;
  localparam int QX_W      = (NUM_W > RATE_W) ? NUM_W : RATE_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_TOUCH = 10'b00_0000_0010,
    S_PRD   = 10'b00_0000_0100,
    S_PCHK  = 10'b00_0000_1000,
    S_LRD   = 10'b00_0001_0000,
    S_LCHK  = 10'b00_0010_0000,
    S_MUL   = 10'b00_0100_0000,
    S_DGO   = 10'b00_1000_0000,
    S_DWAIT = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CH_W-1:0]     ch_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   last_r;
  logic [TIME_W-1:0]   oldest_r;
  logic [TIME_W-1:0]   span_r;
  logic [NUM_W-1:0]    num_r;
  logic [RATE_W-1:0]   rate_r;
  logic                valid_r;
  logic [WIN_W-1:0]    window_r;

  logic [HEAD_W-1:0]   head_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]    count_r [NUM_CHANNELS];
  logic [TIME_W-1:0]   start_r [NUM_CHANNELS];
  logic                seen_r  [NUM_CHANNELS];

  logic [CH_W-1:0]     cur;
  logic [HEAD_W-1:0]   cur_head;
  logic [CNT_W-1:0]    cur_cnt;
  logic [TIME_W-1:0]   cur_start;
  logic                cur_seen;
  logic                rec_ok;
  logic                full;
  logic [HEAD_W-1:0]   head_inc;
  logic [HEAD_W-1:0]   wr_pos;
  logic [HEAD_W-1:0]   last_pos;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [TIME_W-1:0]   rd_data;
  logic [TIME_W-1:0]   age_diff;
  logic                prune;
  logic [TIME_W-1:0]   span;
  logic                is_last;
  logic                div_go;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;
  logic [QX_W-1:0]     quo_x;

  function automatic logic [HEAD_W-1:0] wrap_pos(input logic [HEAD_W:0] s);
    logic [HEAD_W:0] r;
    r = s;
    if (s >= (HEAD_W+1)'(RING_DEPTH)) begin
      r = s - (HEAD_W+1)'(RING_DEPTH);
    end
    return HEAD_W'(r);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                  input logic [HEAD_W-1:0] pos);
    return ADDR_W'(ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(pos);
  endfunction

  assign cur       = (state_r == S_IDLE) ? CH_W'(in_xact.channel) : ch_r;
  assign cur_head  = head_r[cur];
  assign cur_cnt   = count_r[cur];
  assign cur_start = start_r[cur];
  assign cur_seen  = seen_r[cur];

  assign rec_ok = start && (state_r == S_IDLE) && (in_xact.cmd == CMD_RECORD) &&
                  (int'(in_xact.channel) < NUM_CHANNELS);
  assign full     = cur_cnt == CNT_W'(RING_DEPTH);
  assign head_inc = wrap_pos((HEAD_W+1)'(cur_head) + (HEAD_W+1)'(1));
  assign wr_pos   = full ? cur_head
                         : wrap_pos((HEAD_W+1)'(cur_head) + (HEAD_W+1)'(cur_cnt));
  assign last_pos = wrap_pos((HEAD_W+1)'(cur_head) + (HEAD_W+1)'(cur_cnt)
                             - (HEAD_W+1)'(1));
  assign wr_addr  = slot_addr(cur, wr_pos);
  assign rd_addr  = (state_r == S_PRD) ? slot_addr(cur, cur_head)
                                       : slot_addr(cur, last_pos);

  assign age_diff = now_r - rd_data;
  assign prune    = age_diff > TIME_W'(window_r);
  assign span     = rd_data - oldest_r;
  assign is_last  = ch_r == CH_W'(NUM_CHANNELS - 1);
  assign div_go   = state_r == S_DGO;
  assign quo_x    = QX_W'(div_quo);

  erm_stamp_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (TIME_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (rec_ok),
    .wr_addr (wr_addr),
    .wr_data (in_xact.now_ms),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  erm_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (num_r),
    .den   (span_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && (in_xact.cmd == CMD_REPORT)) begin
          state_nxt = S_TOUCH;
        end
      end
      S_TOUCH: begin
        state_nxt = (cur_cnt == '0) ? S_EMIT : S_PRD;
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!prune) begin
          state_nxt = S_LRD;
        end else if (cur_cnt == CNT_W'(1)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_LRD: begin
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        state_nxt = ((cur_cnt > CNT_W'(1)) && (span != '0)) ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        state_nxt = S_DGO;
      end
      S_DGO: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        state_nxt = is_last ? S_IDLE : S_TOUCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= WINDOW_RESET;
      ch_r     <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
        start_r[i] <= '0;
        seen_r[i]  <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (rec_ok) begin
        seen_r[cur] <= 1'b1;
        if (!cur_seen) begin
          start_r[cur] <= in_xact.now_ms;
        end
        if (full) begin
          head_r[cur] <= head_inc;
        end else begin
          count_r[cur] <= cur_cnt + CNT_W'(1);
        end
      end
      case (state_r)
        S_IDLE: begin
          ch_r <= '0;
        end
        S_TOUCH: begin
          if (!cur_seen) begin
            seen_r[cur]  <= 1'b1;
            start_r[cur] <= now_r;
          end
        end
        S_PCHK: begin
          if (prune) begin
            head_r[cur]  <= head_inc;
            count_r[cur] <= cur_cnt - CNT_W'(1);
          end
        end
        S_EMIT: begin
          ch_r <= ch_r + CH_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        now_r <= in_xact.now_ms;
      end
      S_TOUCH: begin
        last_r  <= cur_seen ? cur_start : now_r;
        valid_r <= 1'b0;
        rate_r  <= '0;
      end
      S_PCHK: begin
        last_r   <= cur_start;
        oldest_r <= rd_data;
      end
      S_LCHK: begin
        last_r <= rd_data;
        span_r <= span;
      end
      S_MUL: begin
        num_r <= NUM_W'(cur_cnt - CNT_W'(1)) * NUM_W'(RATE_SCALE);
      end
      S_DWAIT: begin
        if (div_done) begin
          valid_r <= 1'b1;
          rate_r  <= (quo_x > QX_W'(RATE_MAX)) ? RATE_MAX : RATE_W'(div_quo);
        end
      end
      default: begin
      end
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_EMIT;

  always_comb begin
    out_xact.chan_id      = CHAN_W'(ch_r);
    out_xact.age_ms       = now_r - last_r;
    out_xact.rate_valid   = valid_r;
    out_xact.rate_centihz = rate_r;
    out_xact.last_result  = is_last;
  end

endmodule

### hw/rtl/erm_checker.sv
// erm_checker: port-level assertions on the monitor top, attached by bind
// depends on erm_pkg and event_rate_and_age_monitor_top
module erm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input erm_pkg::in_xact_t  in_xact,
  input logic               out_valid,
  input erm_pkg::out_xact_t out_xact
);

  import erm_pkg::*;

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a report");

  a_record_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_xact.cmd == CMD_RECORD)) |=> !busy)
    else $error("record left the block busy");

  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_xact.last_result) |=> !busy)
    else $error("block still busy after last result");

  a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_xact.last_result) |=> !out_valid)
    else $error("results back to back");

  a_rate_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_xact.rate_valid) |-> (out_xact.rate_centihz == '0))
    else $error("rate nonzero without valid rate");

endmodule

bind event_rate_and_age_monitor_top erm_checker u_erm_checker (.*);
